// ===== src/mbm_pkg.sv =====
package mbm_pkg;

   localparam int IDX_W = 10;
   localparam int VAL_W = 32;

   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 16;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [IDX_W-1:0] LAST_RESET = 10'd1023;

   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic signed [VAL_W-1:0] val_type;

   typedef struct packed {
      logic load_wr;
      logic query_start;
      logic scan_step;
      logic result_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hit;
      logic exhausted;
   } dp_sts_type;

endpackage

// ===== src/mbm_dpath.sv =====
module mbm_dpath #(
   parameter int GRID_DEPTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  mbm_pkg::idx_type       csr_wdata,
   input  mbm_pkg::idx_type       entry_index,
   input  mbm_pkg::val_type       entry_value,
   input  mbm_pkg::val_type       query_value,
   input  logic                   start_column,
   input  mbm_pkg::ctrl_cmd_type  cmd,
   output mbm_pkg::dp_sts_type    sts,
   output mbm_pkg::idx_type       bracket_index,
   output logic                   found
);

   localparam int AW = $clog2(GRID_DEPTH);
   localparam int CW = 17;

   mbm_pkg::val_type grid_mem [GRID_DEPTH];

   mbm_pkg::idx_type last_ff, last_in;
   mbm_pkg::idx_type march_ff, march_in;
   mbm_pkg::idx_type rd_ff, rd_in;
   mbm_pkg::idx_type hi_ff, hi_in;
   mbm_pkg::val_type q_ff, q_in;
   mbm_pkg::val_type prev_ff;
   mbm_pkg::val_type rdata_ff;
   mbm_pkg::idx_type bracket_ff, bracket_in;
   logic             found_ff, found_in;

   logic [CW-1:0]    grid_top;
   mbm_pkg::idx_type last_eff;
   mbm_pkg::idx_type pos_eff;
   logic             load_ok;
   logic [AW-1:0]    rd_addr;
   logic             pair_ok;
   logic             brk;

   assign grid_top = CW'(GRID_DEPTH - 1);
   assign last_eff = (CW'(last_ff) > grid_top) ? mbm_pkg::IDX_W'(grid_top) : last_ff;
   assign load_ok  = CW'(entry_index) < CW'(GRID_DEPTH);
   assign pos_eff  = start_column ? '0 : march_ff;
   assign rd_addr  = cmd.query_start ? AW'(pos_eff) : AW'(rd_ff);

   // grid: single port, registered read
   always_ff @(posedge clock) begin
      if (cmd.load_wr && load_ok) begin
         grid_mem[AW'(entry_index)] <= entry_value;
      end
      if (cmd.query_start || cmd.scan_step) begin
         rdata_ff <= grid_mem[rd_addr];
      end
      if (cmd.scan_step) begin
         prev_ff <= rdata_ff;
      end
   end

   assign pair_ok = hi_ff != march_ff;
   assign brk     = (prev_ff <= q_ff && rdata_ff >= q_ff) ||
                    (prev_ff >= q_ff && rdata_ff <= q_ff);

   assign sts.hit       = pair_ok && brk;
   assign sts.exhausted = hi_ff >= last_eff;

   always_comb begin
      last_in    = last_ff;
      march_in   = march_ff;
      rd_in      = rd_ff;
      hi_in      = hi_ff;
      q_in       = q_ff;
      bracket_in = bracket_ff;
      found_in   = found_ff;
      if (csr_we) begin
         last_in = csr_wdata;
      end
      if (cmd.query_start) begin
         march_in = pos_eff;
         hi_in    = pos_eff;
         rd_in    = pos_eff + 1'b1;
         q_in     = query_value;
      end
      if (cmd.scan_step) begin
         hi_in = rd_ff;
         rd_in = rd_ff + 1'b1;
      end
      if (cmd.result_load) begin
         found_in = sts.hit;
         if (sts.hit) begin
            bracket_in = hi_ff - 1'b1;
            march_in   = hi_ff - 1'b1;
         end else begin
            bracket_in = march_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= mbm_pkg::LAST_RESET;
         march_ff <= '0;
      end else begin
         last_ff  <= last_in;
         march_ff <= march_in;
      end
      rd_ff      <= rd_in;
      hi_ff      <= hi_in;
      q_ff       <= q_in;
      bracket_ff <= bracket_in;
      found_ff   <= found_in;
   end

   assign bracket_index = bracket_ff;
   assign found         = found_ff;

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> rd_ff <= last_eff)
      else $error("grid read beyond last index");

   a_march_below_last: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load && sts.hit |=> march_ff < last_eff)
      else $error("march position past last interval");

endmodule

// ===== src/mbm_ctrl.sv =====
module mbm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_action,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  mbm_pkg::dp_sts_type    sts,
   output mbm_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      done;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign done     = sts.hit || sts.exhausted;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_action == mbm_pkg::ACT_QUERY) begin
                  cmd.query_start = 1'b1;
                  state_in        = ST_SCAN;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (done) begin
               if (out_free) begin
                  cmd.result_load = 1'b1;
                  rsp_valid_in    = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result word overwritten");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.result_load))
      else $error("response without result");

   a_query_enters_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.query_start |=> state_ff == ST_SCAN && !rsp_valid_ff || state_ff == ST_SCAN)
      else $error("query not followed by scan");

endmodule

// ===== src/monotone_bracket_march.sv =====
// Marching bracket search over a loaded grid of signed Q8.24 values. A word
// with tuser 0 writes one grid entry; a word with tuser 1
// is a query and returns one word holding the lower index of the first
// interval, at or after the kept position, whose end values enclose the query
// (equality counts), plus a found flag. The position follows each hit, and
// start_column puts it back to 0. A query reads the grid entries after the
// one at the kept position in turn, up to the hit or the last index, since
// the grid memory has one port and gives one entry per cycle. The grid is
// not cleared: every entry a query can reach must be written first. The
// next word is taken while a result still waits on the response side.
module monotone_bracket_march #(
   parameter int GRID_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_index, entry_value, query_value, start_column, zero pad
   input  logic [mbm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // action
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // bracket_index, found, zero pad
   output logic [mbm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [mbm_pkg::IDX_W-1:0]         csr_wdata
);

   mbm_pkg::ctrl_cmd_type cmd;
   mbm_pkg::dp_sts_type   sts;
   mbm_pkg::idx_type      bracket_index;
   logic                  found;

   mbm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mbm_dpath #(
      .GRID_DEPTH (GRID_DEPTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .entry_index   (req_tdata[9:0]),
      .entry_value   (req_tdata[41:10]),
      .query_value   (req_tdata[73:42]),
      .start_column  (req_tdata[74]),
      .cmd           (cmd),
      .sts           (sts),
      .bracket_index (bracket_index),
      .found         (found)
   );

   assign rsp_tdata = mbm_pkg::RSP_TDATA_W'({found, bracket_index});

endmodule
